// ===== rtl/bsdv_pkg.sv =====
// Shared types, constants and helpers for the BSON document validator.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package bsdv_pkg;

    // Largest declared document length that is accepted
    localparam int unsigned MAX_DOC_BYTES = 65536;
    // Byte position counter saturates at MAX_DOC_BYTES + 1
    localparam int unsigned POS_W = $clog2(MAX_DOC_BYTES + 2);

    localparam int unsigned DATA_W     = 8;
    localparam int unsigned MASK_W     = 32;
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned OFFSET_W   = 16;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [MASK_W-1:0] MASK_RESET = 32'h0005_013C;

    // Element type codes handled at the top level
    localparam logic [7:0] T_STRING = 8'h02;
    localparam logic [7:0] T_DOC    = 8'h03;
    localparam logic [7:0] T_ARRAY  = 8'h04;
    localparam logic [7:0] T_BINARY = 8'h05;
    localparam logic [7:0] T_BOOL   = 8'h08;
    localparam logic [7:0] T_INT32  = 8'h10;
    localparam logic [7:0] T_INT64  = 8'h12;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_LENGTH   = 3'd1,
        ERR_NO_ZERO  = 3'd2,
        ERR_TYPE     = 3'd3,
        ERR_STR_TERM = 3'd4,
        ERR_DOC_TERM = 3'd5,
        ERR_BOOL     = 3'd6,
        ERR_OVERRUN  = 3'd7
    } err_t;

    localparam logic REC_ELEMENT = 1'b0;
    localparam logic REC_VERDICT = 1'b1;

    // One result record
    typedef struct packed {
        logic                kind;
        logic [7:0]          etype;
        logic [OFFSET_W-1:0] offset;
        logic                ok;
        err_t                code;
    } rec_t;

    // Input byte as held in the input register
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } in_item_t;

    function automatic logic is_known_type(input logic [7:0] t);
        return (t == T_STRING) || (t == T_DOC) || (t == T_ARRAY) ||
               (t == T_BINARY) || (t == T_BOOL) || (t == T_INT32) ||
               (t == T_INT64);
    endfunction

endpackage

// ===== rtl/bsdv_in_reg.sv =====
// Input register stage of the BSON document validator.
// Depends on bsdv_pkg for the input item type.
module bsdv_in_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bsdv_pkg::in_item_t in_item,
    input  logic              advance,
    output logic              held_valid,
    output bsdv_pkg::in_item_t held_item
);

    logic               valid_reg;
    logic               valid_next;
    bsdv_pkg::in_item_t item_reg;

    // Take a new byte when empty or when the held one moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ===== rtl/bsdv_parser.sv =====
// Byte-step parser for the top-level BSON element list, with the type mask register.
// Depends on bsdv_pkg for constants, record type and error codes.
module bsdv_parser
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bsdv_pkg::MASK_W-1:0]    cfg_wr_data,
    input  logic                           step,
    input  bsdv_pkg::in_item_t             item,
    output logic                           rec_valid,
    output bsdv_pkg::rec_t                 rec
);

    typedef enum logic [3:0] {
        PH_HDR  = 4'd0,
        PH_TYPE = 4'd1,
        PH_NAME = 4'd2,
        PH_LEN0 = 4'd3,
        PH_LEN1 = 4'd4,
        PH_LEN2 = 4'd5,
        PH_LEN3 = 4'd6,
        PH_BOOL = 4'd7,
        PH_SKIP = 4'd8,
        PH_TAIL = 4'd9,
        PH_ERR  = 4'd10
    } phase_t;

    localparam int unsigned POS_W = bsdv_pkg::POS_W;
    localparam int unsigned LEN_W = bsdv_pkg::LEN_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(bsdv_pkg::MAX_DOC_BYTES);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(bsdv_pkg::MAX_DOC_BYTES);

    logic [bsdv_pkg::MASK_W-1:0] mask_reg;
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [LEN_W-1:0]            decl_reg, decl_next;
    phase_t                      phase_reg, phase_next;
    logic [7:0]                  type_reg, type_next;
    logic [LEN_W-1:0]            acc_reg, acc_next;
    logic [LEN_W-1:0]            skip_reg, skip_next;
    bsdv_pkg::err_t              err_reg, err_next;

    logic [7:0]       b;
    logic [POS_W-1:0] pos_plus1;
    logic [LEN_W-1:0] len_full;
    logic [LEN_W-1:0] skip_dec;
    logic             type_ok;
    logic             decl_bad;
    bsdv_pkg::err_t   verdict_code;

    assign b         = item.data;
    assign pos_plus1 = pos_reg + POS_W'(1);
    assign len_full  = {b, acc_reg[23:0]};
    assign skip_dec  = (skip_reg != '0) ? skip_reg - LEN_W'(1) : skip_reg;
    assign type_ok   = (b[7:5] == 3'd0) && mask_reg[b[4:0]] && bsdv_pkg::is_known_type(b);

    always_comb
    begin
        pos_next   = pos_reg;
        decl_next  = decl_reg;
        phase_next = phase_reg;
        type_next  = type_reg;
        acc_next   = acc_reg;
        skip_next  = skip_reg;
        err_next   = err_reg;
        rec_valid  = 1'b0;
        rec        = '{kind: bsdv_pkg::REC_ELEMENT, etype: 8'd0, offset: '0,
                       ok: 1'b0, code: bsdv_pkg::ERR_NONE};
        decl_bad     = 1'b0;
        verdict_code = bsdv_pkg::ERR_NONE;

        if (step)
        begin
            unique case (phase_reg)
                PH_HDR:
                begin
                    // Assemble the little-endian declared length
                    if (pos_reg < POS_W'(4))
                    begin
                        case (pos_reg[1:0])
                            2'd0:    decl_next = {24'd0, b};
                            2'd1:    decl_next[15:8] = b;
                            2'd2:    decl_next[23:16] = b;
                            default: decl_next[31:24] = b;
                        endcase
                    end
                    if (pos_reg >= POS_W'(3))
                    begin
                        if (decl_next < LEN_W'(5) || decl_next > MAX_LEN)
                        begin
                            phase_next = PH_TAIL;
                        end
                        else
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                end
                PH_TAIL, PH_ERR:
                begin
                end
                default:
                begin
                    if (LEN_W'(pos_plus1) == decl_reg)
                    begin
                        // Byte at the document terminator: element must be complete
                        if (phase_reg != PH_TYPE)
                        begin
                            err_next   = bsdv_pkg::ERR_OVERRUN;
                            phase_next = PH_ERR;
                        end
                        else
                        begin
                            phase_next = PH_TAIL;
                        end
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_TYPE:
                            begin
                                if (type_ok)
                                begin
                                    type_next  = b;
                                    phase_next = PH_NAME;
                                    rec_valid  = 1'b1;
                                    rec.etype  = b;
                                    rec.offset = bsdv_pkg::OFFSET_W'(pos_plus1);
                                end
                                else
                                begin
                                    err_next   = bsdv_pkg::ERR_TYPE;
                                    phase_next = PH_ERR;
                                end
                            end
                            PH_NAME:
                            begin
                                if (b == 8'd0)
                                begin
                                    if (type_reg == bsdv_pkg::T_BOOL)
                                    begin
                                        phase_next = PH_BOOL;
                                    end
                                    else if (type_reg == bsdv_pkg::T_INT32)
                                    begin
                                        skip_next  = LEN_W'(4);
                                        phase_next = PH_SKIP;
                                    end
                                    else if (type_reg == bsdv_pkg::T_INT64)
                                    begin
                                        skip_next  = LEN_W'(8);
                                        phase_next = PH_SKIP;
                                    end
                                    else
                                    begin
                                        phase_next = PH_LEN0;
                                    end
                                end
                            end
                            PH_LEN0:
                            begin
                                acc_next   = {24'd0, b};
                                phase_next = PH_LEN1;
                            end
                            PH_LEN1:
                            begin
                                acc_next[15:8] = b;
                                phase_next     = PH_LEN2;
                            end
                            PH_LEN2:
                            begin
                                acc_next[23:16] = b;
                                phase_next      = PH_LEN3;
                            end
                            PH_LEN3:
                            begin
                                acc_next = len_full;
                                if (len_full[LEN_W-1])
                                begin
                                    err_next   = bsdv_pkg::ERR_OVERRUN;
                                    phase_next = PH_ERR;
                                end
                                else if (type_reg == bsdv_pkg::T_STRING)
                                begin
                                    if (len_full == '0)
                                    begin
                                        err_next   = bsdv_pkg::ERR_OVERRUN;
                                        phase_next = PH_ERR;
                                    end
                                    else
                                    begin
                                        skip_next  = len_full;
                                        phase_next = PH_SKIP;
                                    end
                                end
                                else if (type_reg == bsdv_pkg::T_DOC ||
                                         type_reg == bsdv_pkg::T_ARRAY)
                                begin
                                    if (len_full < LEN_W'(5))
                                    begin
                                        err_next   = bsdv_pkg::ERR_OVERRUN;
                                        phase_next = PH_ERR;
                                    end
                                    else
                                    begin
                                        skip_next  = len_full - LEN_W'(4);
                                        phase_next = PH_SKIP;
                                    end
                                end
                                else
                                begin
                                    // Binary: subtype byte plus payload
                                    skip_next  = len_full + LEN_W'(1);
                                    phase_next = PH_SKIP;
                                end
                            end
                            PH_SKIP:
                            begin
                                skip_next = skip_dec;
                                if (skip_dec == '0)
                                begin
                                    if (type_reg == bsdv_pkg::T_STRING && b != 8'd0)
                                    begin
                                        err_next   = bsdv_pkg::ERR_STR_TERM;
                                        phase_next = PH_ERR;
                                    end
                                    else if ((type_reg == bsdv_pkg::T_DOC ||
                                              type_reg == bsdv_pkg::T_ARRAY) && b != 8'd0)
                                    begin
                                        err_next   = bsdv_pkg::ERR_DOC_TERM;
                                        phase_next = PH_ERR;
                                    end
                                    else
                                    begin
                                        phase_next = PH_TYPE;
                                    end
                                end
                            end
                            PH_BOOL:
                            begin
                                if (b > 8'd1)
                                begin
                                    err_next   = bsdv_pkg::ERR_BOOL;
                                    phase_next = PH_ERR;
                                end
                                else
                                begin
                                    phase_next = PH_TYPE;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_ERR;
                            end
                        endcase
                    end
                end
            endcase

            // Saturating byte count
            if (pos_reg <= MAX_POS)
            begin
                pos_next = pos_plus1;
            end

            if (item.last)
            begin
                decl_bad = (decl_next < LEN_W'(5)) || (decl_next > MAX_LEN);
                if (pos_next < POS_W'(4))
                begin
                    verdict_code = bsdv_pkg::ERR_LENGTH;
                end
                else if (decl_bad)
                begin
                    verdict_code = bsdv_pkg::ERR_OVERRUN;
                end
                else if (LEN_W'(pos_next) != decl_next)
                begin
                    verdict_code = bsdv_pkg::ERR_LENGTH;
                end
                else if (b != 8'd0)
                begin
                    verdict_code = bsdv_pkg::ERR_NO_ZERO;
                end
                else
                begin
                    verdict_code = err_next;
                end
                // Verdict takes the slot; drop any element record of this byte
                rec_valid = 1'b1;
                rec = '{kind: bsdv_pkg::REC_VERDICT, etype: 8'd0, offset: '0,
                        ok: (verdict_code == bsdv_pkg::ERR_NONE), code: verdict_code};
                // Start a fresh document on the next byte
                pos_next   = '0;
                decl_next  = '0;
                phase_next = PH_HDR;
                type_next  = 8'd0;
                acc_next   = '0;
                skip_next  = '0;
                err_next   = bsdv_pkg::ERR_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= bsdv_pkg::MASK_RESET;
            pos_reg   <= '0;
            decl_reg  <= '0;
            phase_reg <= PH_HDR;
            type_reg  <= 8'd0;
            acc_reg   <= '0;
            skip_reg  <= '0;
            err_reg   <= bsdv_pkg::ERR_NONE;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
            pos_reg   <= pos_next;
            decl_reg  <= decl_next;
            phase_reg <= phase_next;
            type_reg  <= type_next;
            acc_reg   <= acc_next;
            skip_reg  <= skip_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== rtl/bsdv_out_reg.sv =====
// Result register of the BSON document validator, driving the master stream.
// Depends on bsdv_pkg for the record type.
module bsdv_out_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           rec_valid,
    input  bsdv_pkg::rec_t rec,
    output logic           out_valid,
    input  logic           out_ready,
    output bsdv_pkg::rec_t out_rec
);

    logic           valid_reg;
    logic           valid_next;
    bsdv_pkg::rec_t rec_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = rec_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && rec_valid)
        begin
            rec_reg <= rec;
        end
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

endmodule

// ===== rtl/bson_document_validator_top.sv =====
// Top level of the BSON document validator: input register, parser, result register.
// Depends on bsdv_pkg, bsdv_in_reg, bsdv_parser and bsdv_out_reg.
//
// Usage:
//   s_axis carries the document one byte per transaction: tdata is the byte,
//   tlast marks the final byte of the buffer.
//   m_axis carries zero or one record per byte. tuser[0] is the record kind
//   (0 element, 1 verdict). An element record gives the type code and the
//   offset of the element name; a verdict record gives pass/fail and the
//   first error code. After the verdict the next byte starts a new document.
//   cfg_wr_en/cfg_wr_data write the supported type mask; write only while idle.
// Timing:
//   One byte per cycle sustained while m_axis_tready stays high. An accepted
//   byte waits in the input register until the parser steps it and loads the
//   result register. The parser's one-byte state update sets the rate.
// Reset:
//   rst_n clears the registers, the parser goes back to the header and the
//   type mask returns to types 2,3,4,5,8,16,18.
// Stall:
//   While m_axis_tready is low the result is held, one more byte waits in the
//   input register, and s_axis_tready then drops.
module bson_document_validator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] type_code, [23:8] name_offset,
                                        // [24] verdict_ok, [27:25] error_code, [31:28] zero
    output logic [0:0]  m_axis_tuser,   // [0] record_kind
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data     // supported_type_mask
);

    logic               held_valid;
    bsdv_pkg::in_item_t in_item;
    bsdv_pkg::in_item_t held_item;
    logic               advance;
    logic               rec_valid;
    bsdv_pkg::rec_t     rec;
    bsdv_pkg::rec_t     out_rec;

    assign in_item = '{data: s_axis_tdata, last: s_axis_tlast};

    // Advance the held byte whenever the result slot is free or draining
    assign advance = held_valid && (!m_axis_tvalid || m_axis_tready);

    bsdv_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    bsdv_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .item        (held_item),
        .rec_valid   (rec_valid),
        .rec         (rec)
    );

    bsdv_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .rec_valid (rec_valid),
        .rec       (rec),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec)
    );

    // Pack the record fields, lowest field first
    assign m_axis_tdata = {4'd0, out_rec.code, out_rec.ok, out_rec.offset, out_rec.etype};
    assign m_axis_tuser = out_rec.kind;

    // An empty input register always takes a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !held_valid |-> s_axis_tready)
        else $error("input register empty but s_axis_tready low");

    // A held byte stays put while its predecessor's result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        held_valid && m_axis_tvalid && !m_axis_tready |=> held_valid)
        else $error("held byte lost during output stall");

    // A verdict passes exactly when no error is reported
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[24] == (m_axis_tdata[27:25] == 3'd0)))
        else $error("verdict_ok disagrees with error_code");

    // Element records carry a known type, no verdict and no error
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            bsdv_pkg::is_known_type(m_axis_tdata[7:0]) && !m_axis_tdata[24] &&
            (m_axis_tdata[27:25] == 3'd0))
        else $error("malformed element record");

    // Records are produced only by a parser step
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) && !$past(m_axis_tvalid) |-> !m_axis_tvalid)
        else $error("record appeared without a parser step");

endmodule

// ===== test/bson_document_validator_top_tb.sv =====
// Self-checking testbench for bson_document_validator_top: streams BSON buffers
// byte by byte and checks every element record and verdict against a local predictor.
// Depends on bsdv_pkg and bson_document_validator_top from rtl/.
`timescale 1ns / 100ps

module bson_document_validator_top_tb;

    // Walk states of the local document predictor
    typedef enum logic [3:0] {
        P_HEADER,
        P_TYPE,
        P_NAME,
        P_LEN0,
        P_LEN1,
        P_LEN2,
        P_LEN3,
        P_BOOL,
        P_SKIP,
        P_TAIL,
        P_ERROR
    } walk_t;

    // Ways to break an otherwise well-formed document
    typedef enum int unsigned {
        FLIP_BYTE,
        CUT_TAIL,
        EXTRA_BYTES,
        SKEW_LENGTH,
        NONZERO_END,
        WILD_LENGTH
    } damage_t;

    // One byte waiting to go out on the slave side
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;    // last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [7:0] type_code, [23:8] name_offset,
                                         // [24] verdict_ok, [27:25] error_code
    logic [0:0]  m_axis_tuser;           // [0] record_kind
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = 32'h0;    // supported_type_mask

    // Stimulus and scoreboard storage
    stream_byte_t   byte_queue[$];
    bsdv_pkg::rec_t expected_records[$];
    logic [7:0]     doc_buf[$];

    // Set during one phase to run both sides without any idle cycles
    logic steady = 1'b0;

    int unsigned mismatches = 0;
    int unsigned elements_checked = 0;
    int unsigned verdicts_checked = 0;
    int unsigned bytes_queued = 0;
    int unsigned buffers_sent = 0;
    int unsigned masks_used = 1;

    // Predictor state: mirrors the block's walk over one document
    logic [31:0]    type_mask = bsdv_pkg::MASK_RESET;
    logic [16:0]    doc_pos = '0;
    logic [31:0]    doc_len = '0;
    walk_t          phase = P_HEADER;
    logic [7:0]     elem_type = '0;
    logic [31:0]    len_acc = '0;
    logic [31:0]    skip_left = '0;
    bsdv_pkg::err_t doc_err = bsdv_pkg::ERR_NONE;

    bson_document_validator_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // Record the first error and stop walking the element list
    function automatic void abort_doc(input bsdv_pkg::err_t code);
        doc_err = code;
        phase   = P_ERROR;
    endfunction

    // Advance the document walk by one byte; return 1 when a record results
    function automatic logic validate_byte(input logic [7:0] b, input logic fin,
                                           output bsdv_pkg::rec_t rec);
        logic [16:0]    p;
        logic [31:0]    len;
        logic           has_rec;
        bsdv_pkg::err_t code;

        p       = doc_pos;
        has_rec = 1'b0;
        rec     = '0;

        if (phase == P_HEADER)
        begin
            // Little-endian declared length in the first four bytes
            if (p < 4)
            begin
                if (p == 0)
                    doc_len = {24'd0, b};
                else
                    doc_len = doc_len | ({24'd0, b} << (8 * p));
            end
            if (p >= 3)
                phase = (doc_len < 5 || doc_len > bsdv_pkg::MAX_DOC_BYTES) ?
                        P_TAIL : P_TYPE;
        end
        else if (phase == P_TAIL || phase == P_ERROR)
        begin
            // Only counting from here on
        end
        else if (32'(p) + 32'd1 == doc_len)
        begin
            // Document terminator position: any open element has overrun
            if (phase != P_TYPE)
                abort_doc(bsdv_pkg::ERR_OVERRUN);
            else
                phase = P_TAIL;
        end
        else
        begin
            case (phase)
                P_TYPE:
                begin
                    if (b < 32 && type_mask[b[4:0]] &&
                        (b inside {bsdv_pkg::T_STRING, bsdv_pkg::T_DOC,
                                   bsdv_pkg::T_ARRAY, bsdv_pkg::T_BINARY,
                                   bsdv_pkg::T_BOOL, bsdv_pkg::T_INT32,
                                   bsdv_pkg::T_INT64}))
                    begin
                        elem_type   = b;
                        phase       = P_NAME;
                        rec.kind    = bsdv_pkg::REC_ELEMENT;
                        rec.etype   = b;
                        rec.offset  = 16'(p + 17'd1);
                        rec.ok      = 1'b0;
                        rec.code    = bsdv_pkg::ERR_NONE;
                        has_rec     = 1'b1;
                    end
                    else
                        abort_doc(bsdv_pkg::ERR_TYPE);
                end
                P_NAME:
                begin
                    if (b == 8'h00)
                    begin
                        case (elem_type)
                            bsdv_pkg::T_BOOL:  phase = P_BOOL;
                            bsdv_pkg::T_INT32:
                            begin
                                skip_left = 32'd4;
                                phase     = P_SKIP;
                            end
                            bsdv_pkg::T_INT64:
                            begin
                                skip_left = 32'd8;
                                phase     = P_SKIP;
                            end
                            default: phase = P_LEN0;
                        endcase
                    end
                end
                P_LEN0:
                begin
                    len_acc = {24'd0, b};
                    phase   = P_LEN1;
                end
                P_LEN1:
                begin
                    len_acc[15:8] = b;
                    phase         = P_LEN2;
                end
                P_LEN2:
                begin
                    len_acc[23:16] = b;
                    phase          = P_LEN3;
                end
                P_LEN3:
                begin
                    len     = {b, len_acc[23:0]};
                    len_acc = len;
                    if (len[31])
                        abort_doc(bsdv_pkg::ERR_OVERRUN);
                    else if (elem_type == bsdv_pkg::T_STRING)
                    begin
                        if (len == 0)
                            abort_doc(bsdv_pkg::ERR_OVERRUN);
                        else
                        begin
                            skip_left = len;
                            phase     = P_SKIP;
                        end
                    end
                    else if (elem_type == bsdv_pkg::T_DOC || elem_type == bsdv_pkg::T_ARRAY)
                    begin
                        if (len < 5)
                            abort_doc(bsdv_pkg::ERR_OVERRUN);
                        else
                        begin
                            skip_left = len - 32'd4;
                            phase     = P_SKIP;
                        end
                    end
                    else
                    begin
                        // Binary: subtype byte plus payload
                        skip_left = len + 32'd1;
                        phase     = P_SKIP;
                    end
                end
                P_SKIP:
                begin
                    if (skip_left > 0)
                        skip_left = skip_left - 32'd1;
                    if (skip_left == 0)
                    begin
                        if (elem_type == bsdv_pkg::T_STRING && b != 8'h00)
                            abort_doc(bsdv_pkg::ERR_STR_TERM);
                        else if ((elem_type == bsdv_pkg::T_DOC ||
                                  elem_type == bsdv_pkg::T_ARRAY) && b != 8'h00)
                            abort_doc(bsdv_pkg::ERR_DOC_TERM);
                        else
                            phase = P_TYPE;
                    end
                end
                P_BOOL:
                begin
                    if (b > 8'h01)
                        abort_doc(bsdv_pkg::ERR_BOOL);
                    else
                        phase = P_TYPE;
                end
                default: phase = P_ERROR;
            endcase
        end

        // Position saturates one past the largest legal document
        if (p <= bsdv_pkg::MAX_DOC_BYTES)
            doc_pos = p + 17'd1;

        if (fin)
        begin
            if (doc_pos < 4)
                code = bsdv_pkg::ERR_LENGTH;
            else if (doc_len < 5 || doc_len > bsdv_pkg::MAX_DOC_BYTES)
                code = bsdv_pkg::ERR_OVERRUN;
            else if (32'(doc_pos) != doc_len)
                code = bsdv_pkg::ERR_LENGTH;
            else if (b != 8'h00)
                code = bsdv_pkg::ERR_NO_ZERO;
            else
                code = doc_err;
            // The verdict takes the only result slot of this byte
            rec.kind   = bsdv_pkg::REC_VERDICT;
            rec.etype  = 8'h00;
            rec.offset = '0;
            rec.ok     = (code == bsdv_pkg::ERR_NONE);
            rec.code   = code;
            has_rec    = 1'b1;
            // Next byte starts a fresh document
            doc_pos    = '0;
            doc_len    = '0;
            phase      = P_HEADER;
            elem_type  = '0;
            len_acc    = '0;
            skip_left  = '0;
            doc_err    = bsdv_pkg::ERR_NONE;
        end
        return has_rec;
    endfunction

    //------------------------------------------------------------------
    // Driver: present queued bytes, predict on every accepted transaction
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        bsdv_pkg::rec_t rec;
        stream_byte_t   nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (validate_byte(s_axis_tdata, s_axis_tlast, rec))
                    expected_records.push_back(rec);
            end
            // Hold the current byte until it is taken; otherwise load or idle
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (byte_queue.size() > 0 && (steady || $urandom_range(99) >= 26))
                begin
                    nxt = byte_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tlast  <= nxt.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Monitor: random back-pressure, compare each record with the oldest
    // expectation
    //------------------------------------------------------------------
    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bsdv_pkg::rec_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_records.size() == 0)
                begin
                    $display("%0t: unexpected record, expected none,", $time,
                             " actual tdata 0x%h tuser %b", m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_records.pop_front();
                    check_field("record_kind", want.kind, m_axis_tuser[0]);
                    check_field("type_code", want.etype, m_axis_tdata[7:0]);
                    check_field("name_offset", want.offset, m_axis_tdata[23:8]);
                    check_field("verdict_ok", want.ok, m_axis_tdata[24]);
                    check_field("error_code", want.code, m_axis_tdata[27:25]);
                    check_field("tdata padding", 0, m_axis_tdata[31:28]);
                    if (want.kind == bsdv_pkg::REC_VERDICT)
                        verdicts_checked++;
                    else
                        elements_checked++;
                end
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 26);
        end
    end

    //------------------------------------------------------------------
    // Document builders
    //------------------------------------------------------------------
    task automatic put8(input logic [7:0] v);
        doc_buf.push_back(v);
    endtask

    task automatic put32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            doc_buf.push_back(v[8*i +: 8]);
    endtask

    // Overwrite the declared length in the header
    task automatic set_len(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            doc_buf[i] = v[8*i +: 8];
    endtask

    task automatic open_doc();
        doc_buf.delete();
        put32(32'd0);
    endtask

    // Append the terminator and patch the header to the true size
    task automatic close_doc();
        put8(8'h00);
        set_len(32'(doc_buf.size()));
    endtask

    // Well-formed element; size sets the payload of variable-length types
    task automatic add_element(input logic [7:0] t, input int unsigned name_len,
                               input int unsigned size);
        put8(t);
        repeat (name_len) put8(8'($urandom_range(255, 1)));
        put8(8'h00);
        case (t)
            bsdv_pkg::T_STRING:
            begin
                put32(32'(size + 1));
                repeat (size) put8(8'($urandom_range(255)));
                put8(8'h00);
            end
            bsdv_pkg::T_DOC, bsdv_pkg::T_ARRAY:
            begin
                put32(32'(size + 5));
                repeat (size) put8(8'($urandom_range(255)));
                put8(8'h00);
            end
            bsdv_pkg::T_BINARY:
            begin
                put32(32'(size));
                repeat (size + 1) put8(8'($urandom_range(255)));
            end
            bsdv_pkg::T_BOOL:  put8(8'($urandom_range(1)));
            bsdv_pkg::T_INT32: repeat (4) put8(8'($urandom_range(255)));
            bsdv_pkg::T_INT64: repeat (8) put8(8'($urandom_range(255)));
            default: ;
        endcase
    endtask

    // Queue the built buffer, flagging its final byte
    task automatic send_buf();
        foreach (doc_buf[i])
            byte_queue.push_back('{data: doc_buf[i], last: (i == doc_buf.size() - 1)});
        bytes_queued += doc_buf.size();
        buffers_sent++;
    endtask

    // Mostly valid documents with random content, some damaged, some noise
    task automatic random_docs(input int unsigned goal);
        int unsigned start;
        int unsigned idx;
        logic [7:0]  t;
        start = bytes_queued;
        while (bytes_queued - start < goal)
        begin
            if ($urandom_range(99) < 10)
            begin
                doc_buf.delete();
                repeat ($urandom_range(10, 1)) put8(8'($urandom_range(255)));
            end
            else
            begin
                open_doc();
                repeat ($urandom_range(4))
                begin
                    case ($urandom_range(7))
                        0: t = bsdv_pkg::T_STRING;
                        1: t = bsdv_pkg::T_DOC;
                        2: t = bsdv_pkg::T_ARRAY;
                        3: t = bsdv_pkg::T_BINARY;
                        4: t = bsdv_pkg::T_BOOL;
                        5: t = bsdv_pkg::T_INT32;
                        6: t = bsdv_pkg::T_INT64;
                        default: t = 8'($urandom_range(255));
                    endcase
                    add_element(t, $urandom_range(3), $urandom_range(6));
                end
                close_doc();
                if ($urandom_range(99) < 25)
                begin
                    case (damage_t'($urandom_range(5)))
                        FLIP_BYTE:
                        begin
                            idx = $urandom_range(doc_buf.size() - 1);
                            doc_buf[idx] = doc_buf[idx] ^ 8'($urandom_range(255, 1));
                        end
                        CUT_TAIL:
                            repeat ($urandom_range(3, 1))
                                if (doc_buf.size() > 1)
                                    void'(doc_buf.pop_back());
                        EXTRA_BYTES:
                            repeat ($urandom_range(3, 1)) put8(8'($urandom_range(255)));
                        SKEW_LENGTH:
                            set_len(32'(doc_buf.size()) + 32'($urandom_range(4)) - 32'd2);
                        NONZERO_END:
                            doc_buf[doc_buf.size() - 1] = 8'($urandom_range(255, 1));
                        default:
                            set_len($urandom);
                    endcase
                end
            end
            send_buf();
        end
    endtask

    // Let everything drain, then allow for the two-stage pipeline
    task automatic wait_idle();
        while (byte_queue.size() != 0 || s_axis_tvalid || expected_records.size() != 0)
            @(negedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_mask(input logic [31:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        type_mask    = v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        masks_used++;
    endtask

    //------------------------------------------------------------------
    // Stimulus sequence
    //------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Empty document: the smallest that passes
        open_doc();
        close_doc();
        send_buf();

        // Every supported type once
        open_doc();
        add_element(bsdv_pkg::T_STRING, 1, 3);
        add_element(bsdv_pkg::T_DOC, 0, 2);
        add_element(bsdv_pkg::T_ARRAY, 2, 0);
        add_element(bsdv_pkg::T_BINARY, 1, 2);
        add_element(bsdv_pkg::T_BOOL, 1, 0);
        add_element(bsdv_pkg::T_INT32, 3, 0);
        add_element(bsdv_pkg::T_INT64, 0, 0);
        close_doc();
        send_buf();

        // Bool value outside 0/1
        open_doc();
        add_element(bsdv_pkg::T_BOOL, 1, 0);
        doc_buf[doc_buf.size() - 1] = 8'hFF;
        close_doc();
        send_buf();

        // String without its terminating zero
        open_doc();
        add_element(bsdv_pkg::T_STRING, 1, 2);
        doc_buf[doc_buf.size() - 1] = 8'h41;
        close_doc();
        send_buf();

        // Subdocument without its terminating zero
        open_doc();
        add_element(bsdv_pkg::T_DOC, 0, 1);
        doc_buf[doc_buf.size() - 1] = 8'h01;
        close_doc();
        send_buf();

        // Zero string length
        open_doc();
        put8(bsdv_pkg::T_STRING);
        put8(8'h00);
        put32(32'd0);
        close_doc();
        send_buf();

        // Array length below the minimum
        open_doc();
        put8(bsdv_pkg::T_ARRAY);
        put8(8'h00);
        put32(32'd4);
        put8(8'h00);
        close_doc();
        send_buf();

        // Negative binary length
        open_doc();
        put8(bsdv_pkg::T_BINARY);
        put8(8'h00);
        put32(32'h8000_0000);
        put8(8'h00);
        close_doc();
        send_buf();

        // Unsupported type codes: low, high, and a zero byte before the end
        for (int k = 0; k < 3; k++)
        begin
            open_doc();
            put8(k == 0 ? 8'h01 : (k == 1 ? 8'hFF : 8'h00));
            put8(8'h00);
            close_doc();
            send_buf();
        end

        // Element still open when the document terminator comes
        open_doc();
        add_element(bsdv_pkg::T_INT64, 0, 0);
        repeat (5) void'(doc_buf.pop_back());
        close_doc();
        send_buf();

        // Declared length too small, too large, and all ones
        open_doc();
        set_len(32'd4);
        send_buf();
        open_doc();
        close_doc();
        set_len(bsdv_pkg::MAX_DOC_BYTES + 1);
        send_buf();
        open_doc();
        put8(8'h10);
        close_doc();
        set_len(32'hFFFF_FFFF);
        send_buf();

        // Declared length one more than the bytes sent
        open_doc();
        add_element(bsdv_pkg::T_INT32, 0, 0);
        close_doc();
        set_len(32'(doc_buf.size() + 1));
        send_buf();

        // Final byte not zero
        open_doc();
        add_element(bsdv_pkg::T_BOOL, 0, 0);
        close_doc();
        doc_buf[doc_buf.size() - 1] = 8'h80;
        send_buf();

        // Buffers shorter than the header
        doc_buf = '{8'h05};
        send_buf();
        doc_buf = '{8'h05, 8'h00, 8'h00};
        send_buf();

        // Final flag on a type byte: the verdict replaces the element record
        open_doc();
        add_element(bsdv_pkg::T_INT32, 0, 0);
        close_doc();
        while (doc_buf.size() > 5)
            void'(doc_buf.pop_back());
        send_buf();

        random_docs(40);

        // All mask bits set, with no idle cycles on either side
        wait_idle();
        write_mask(32'hFFFF_FFFF);
        steady = 1'b1;
        random_docs(60);
        wait_idle();
        steady = 1'b0;

        // Nothing accepted: every element is a type error
        write_mask(32'h0000_0000);
        random_docs(20);
        wait_idle();

        // Random masks drop arbitrary types
        write_mask($urandom);
        random_docs(20);
        wait_idle();
        write_mask($urandom);
        random_docs(20);
        wait_idle();

        $display("Streamed %0d bytes in %0d buffers under %0d type masks",
                 bytes_queued, buffers_sent, masks_used);
        $display("Checked %0d element records and %0d verdicts, %0d mismatches",
                 elements_checked, verdicts_checked, mismatches);
        if (mismatches == 0 && expected_records.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d bytes queued and %0d records outstanding",
                 byte_queue.size(), expected_records.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
